>>> hw/rtl/sedt_pkg.sv
// shared types and constants for the screen edge dwell trigger
package sedt_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned ZONE_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // item kinds
    localparam logic CMD_MOTION = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // zone selector codes
    localparam logic [ZONE_W-1:0] ZONE_LEFT         = 4'd1;
    localparam logic [ZONE_W-1:0] ZONE_TOP_LEFT     = 4'd2;
    localparam logic [ZONE_W-1:0] ZONE_TOP          = 4'd3;
    localparam logic [ZONE_W-1:0] ZONE_TOP_RIGHT    = 4'd4;
    localparam logic [ZONE_W-1:0] ZONE_RIGHT        = 4'd5;
    localparam logic [ZONE_W-1:0] ZONE_BOTTOM_RIGHT = 4'd6;
    localparam logic [ZONE_W-1:0] ZONE_BOTTOM       = 4'd7;
    localparam logic [ZONE_W-1:0] ZONE_BOTTOM_LEFT  = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SELECT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 2'd2;

    // register reset values
    localparam logic [ZONE_W-1:0] ZONE_SELECT_RST   = ZONE_LEFT;
    localparam logic [TICK_W-1:0] DWELL_TICKS_RST   = 16'd0;
    localparam logic [TICK_W-1:0] HOLDOFF_TICKS_RST = 16'd2000;

    typedef struct packed {
        logic fire;
        logic inside_zone;
        logic holdoff_active;
    } t_result;

endpackage

>>> hw/rtl/sedt_in_if.sv
// input channel: motion and tick beats
interface sedt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [sedt_pkg::COORD_W-1:0]   pos_x;
    logic [sedt_pkg::COORD_W-1:0]   pos_y;
    logic [sedt_pkg::COORD_W-1:0]   screen_width;
    logic [sedt_pkg::COORD_W-1:0]   screen_height;

    modport source (output valid, cmd, pos_x, pos_y, screen_width, screen_height,
                    input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, screen_width, screen_height,
                    output ready);
endinterface

>>> hw/rtl/sedt_out_if.sv
// output channel: one result beat per input beat
interface sedt_out_if;
    logic valid;
    logic ready;
    logic fire;
    logic inside_zone;
    logic holdoff_active;

    modport source (output valid, fire, inside_zone, holdoff_active, input ready);
    modport sink   (input valid, fire, inside_zone, holdoff_active, output ready);
endinterface

>>> hw/rtl/sedt_zone.sv
// edge and corner hit test for the selected zone
module sedt_zone (
    input  logic [sedt_pkg::ZONE_W-1:0]  i_zone_select,
    input  logic [sedt_pkg::COORD_W-1:0] i_pos_x,
    input  logic [sedt_pkg::COORD_W-1:0] i_pos_y,
    input  logic [sedt_pkg::COORD_W-1:0] i_screen_width,
    input  logic [sedt_pkg::COORD_W-1:0] i_screen_height,
    output logic                         o_hit
);
    import sedt_pkg::*;

    logic [COORD_W-1:0] s_x_max;
    logic [COORD_W-1:0] s_y_max;
    logic s_l, s_t, s_r, s_b;

    // zero size wraps to the top code
    assign s_x_max = i_screen_width  - COORD_W'(1);
    assign s_y_max = i_screen_height - COORD_W'(1);

    assign s_l = (i_pos_x == '0);
    assign s_t = (i_pos_y == '0);
    assign s_r = (i_pos_x == s_x_max);
    assign s_b = (i_pos_y == s_y_max);

    always_comb begin
        case (i_zone_select)
            ZONE_LEFT:         o_hit = s_l;
            ZONE_TOP_LEFT:     o_hit = s_l & s_t;
            ZONE_TOP:          o_hit = s_t;
            ZONE_TOP_RIGHT:    o_hit = s_r & s_t;
            ZONE_RIGHT:        o_hit = s_r;
            ZONE_BOTTOM_RIGHT: o_hit = s_r & s_b;
            ZONE_BOTTOM:       o_hit = s_b;
            ZONE_BOTTOM_LEFT:  o_hit = s_l & s_b;
            default:           o_hit = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/sedt_ctrl.sv
// visit state, dwell and holdoff counters, trigger decision
module sedt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_cmd,
    input  logic                        i_hit,
    input  logic [sedt_pkg::TICK_W-1:0] i_dwell_ticks,
    input  logic [sedt_pkg::TICK_W-1:0] i_holdoff_ticks,
    output sedt_pkg::t_result           o_result
);
    import sedt_pkg::*;

    logic              r_in_zone,  n_in_zone;
    logic              r_fired,    n_fired;
    logic              r_pending,  n_pending;
    logic [TICK_W-1:0] r_dwell_left,   n_dwell_left;
    logic [TICK_W-1:0] r_holdoff_left, n_holdoff_left;
    logic              s_fire;

    always_comb begin
        n_in_zone      = r_in_zone;
        n_fired        = r_fired;
        n_pending      = r_pending;
        n_dwell_left   = r_dwell_left;
        n_holdoff_left = r_holdoff_left;
        s_fire         = 1'b0;

        if (i_cmd == CMD_MOTION) begin
            if (i_hit) begin
                if (!r_in_zone) begin
                    n_in_zone = 1'b1;
                    n_fired   = 1'b0;
                    n_pending = 1'b0;
                    if (i_dwell_ticks == '0) begin
                        n_dwell_left = '0;
                        if (r_holdoff_left != '0) begin
                            n_pending = 1'b1;
                        end else begin
                            s_fire         = 1'b1;
                            n_fired        = 1'b1;
                            n_holdoff_left = i_holdoff_ticks;
                        end
                    end else begin
                        n_dwell_left = i_dwell_ticks;
                    end
                end
            end else begin
                n_in_zone    = 1'b0;
                n_fired      = 1'b0;
                n_pending    = 1'b0;
                n_dwell_left = '0;
            end
        end else begin
            // holdoff first, a held trigger may fire as it runs out
            if (r_holdoff_left != '0) begin
                n_holdoff_left = r_holdoff_left - TICK_W'(1);
                if (n_holdoff_left == '0 && r_pending) begin
                    n_pending = 1'b0;
                    if (r_in_zone && !r_fired) begin
                        s_fire         = 1'b1;
                        n_fired        = 1'b1;
                        n_holdoff_left = i_holdoff_ticks;
                    end
                end
            end
            // dwell countdown sees the updated fired flag and holdoff
            if (r_in_zone && !n_fired && r_dwell_left != '0) begin
                n_dwell_left = r_dwell_left - TICK_W'(1);
                if (n_dwell_left == '0) begin
                    if (n_holdoff_left != '0) begin
                        n_pending = 1'b1;
                    end else begin
                        s_fire         = 1'b1;
                        n_fired        = 1'b1;
                        n_holdoff_left = i_holdoff_ticks;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_zone      <= 1'b0;
            r_fired        <= 1'b0;
            r_pending      <= 1'b0;
            r_dwell_left   <= '0;
            r_holdoff_left <= '0;
        end else if (i_step) begin
            r_in_zone      <= n_in_zone;
            r_fired        <= n_fired;
            r_pending      <= n_pending;
            r_dwell_left   <= n_dwell_left;
            r_holdoff_left <= n_holdoff_left;
        end
    end

    assign o_result.fire           = s_fire;
    assign o_result.inside_zone    = n_in_zone;
    assign o_result.holdoff_active = (n_holdoff_left != '0);

`ifndef SYNTHESIS
    a_fire_loads_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && s_fire |=> r_holdoff_left == $past(i_holdoff_ticks))
        else $error("holdoff not loaded on fire");

    a_pending_in_visit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_in_zone && !r_fired)
        else $error("pending trigger outside an unfired visit");

    a_pending_needs_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_holdoff_left != '0)
        else $error("pending trigger with holdoff expired");
`endif

endmodule

>>> hw/rtl/screen_edge_dwell_trigger.sv
// screen edge dwell trigger: top level with input stage, result stage and registers
// path: an accepted beat is registered in the input stage, then in the result stage (two stages)
// throughput: one beat per cycle while the output is ready; all state updates in one pass of the control logic
// a stalled result register does not block intake while the input stage is free
// reset: synchronous active low; clears all visit state, valids and configuration registers to defaults
// zone_select resets to left edge, dwell_ticks to 0, holdoff_ticks to 2000
module screen_edge_dwell_trigger (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sedt_in_if.sink                            i_in,
    sedt_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [sedt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sedt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import sedt_pkg::*;

    // configuration registers
    logic [ZONE_W-1:0] r_zone_select;
    logic [TICK_W-1:0] r_dwell_ticks;
    logic [TICK_W-1:0] r_holdoff_ticks;

    // input stage
    logic               r_s1_valid;
    logic               r_cmd;
    logic [COORD_W-1:0] r_pos_x;
    logic [COORD_W-1:0] r_pos_y;
    logic [COORD_W-1:0] r_screen_width;
    logic [COORD_W-1:0] r_screen_height;

    // result stage
    logic    r_out_valid;
    t_result r_result;

    logic    s_in_fire;
    logic    s_advance;
    logic    s_hit;
    t_result s_result;

    // the input stage moves on when the result stage is empty or being drained
    assign s_advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s_advance;
    assign s_in_fire  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_select   <= ZONE_SELECT_RST;
            r_dwell_ticks   <= DWELL_TICKS_RST;
            r_holdoff_ticks <= HOLDOFF_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZONE_SELECT:   r_zone_select   <= i_cfg_data[ZONE_W-1:0];
                CFG_DWELL_TICKS:   r_dwell_ticks   <= i_cfg_data[TICK_W-1:0];
                CFG_HOLDOFF_TICKS: r_holdoff_ticks <= i_cfg_data[TICK_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (s_in_fire) begin
            r_cmd           <= i_in.cmd;
            r_pos_x         <= i_in.pos_x;
            r_pos_y         <= i_in.pos_y;
            r_screen_width  <= i_in.screen_width;
            r_screen_height <= i_in.screen_height;
        end
    end

    sedt_zone u_zone (
        .i_zone_select   (r_zone_select),
        .i_pos_x         (r_pos_x),
        .i_pos_y         (r_pos_y),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_hit           (s_hit)
    );

    // state commits exactly when the beat moves into the result stage
    sedt_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (s_advance),
        .i_cmd           (r_cmd),
        .i_hit           (s_hit),
        .i_dwell_ticks   (r_dwell_ticks),
        .i_holdoff_ticks (r_holdoff_ticks),
        .o_result        (s_result)
    );

    // result stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_result <= s_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.fire           = r_result.fire;
    assign o_out.inside_zone    = r_result.inside_zone;
    assign o_out.holdoff_active = r_result.holdoff_active;

`ifndef SYNTHESIS
    a_fire_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.fire |->
            r_result.inside_zone &&
            (r_result.holdoff_active == (r_holdoff_ticks != '0)))
        else $error("fire beat with inconsistent zone or holdoff flags");

    a_no_advance_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_out.ready |=> r_s1_valid)
        else $error("input stage lost a beat while result stage stalled");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_result))
        else $error("stalled result changed");
`endif

endmodule
